FILE: rtl/decimal_digit_display_formatter_top_defines.svh
// Assertion macros used by ddf_back.
`ifndef DECIMAL_DIGIT_DISPLAY_FORMATTER_TOP_DEFINES_SVH
`define DECIMAL_DIGIT_DISPLAY_FORMATTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define DDF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ddf assertion failed");
`define DDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ddf assertion failed");
`else
`define DDF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DDF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/ddf_pkg.sv
package ddf_pkg;

  localparam int VALUE_W             = 16;
  localparam int REG_W               = 4;
  localparam int CODE_W              = 4;
  localparam int OUT_DATA_W          = 8;
  localparam int DIGIT_POSITIONS_DEF = 8;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [CODE_W-1:0] BLANK_CODE = 4'd15;
  localparam logic [CODE_W-1:0] ZERO_CODE  = 4'd0;

  localparam int                RECIP_SHIFT = 19;
  localparam int                PROD_W      = VALUE_W + RECIP_SHIFT;
  localparam logic [16:0]       RECIP_10    = 17'd52429;

  typedef struct packed {
    logic               zero;
    logic [VALUE_W-1:0] value;
  } ddf_item_t;

endpackage

FILE: rtl/ddf_front.sv
module ddf_front
  import ddf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [VALUE_W-1:0] in_tdata,
  output logic               head_valid,
  output ddf_item_t          head,
  input  logic               head_pop
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  ddf_item_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               push, pop;
  ddf_item_t          item;

  assign in_tready  = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push       = in_tvalid && in_tready;
  assign head_valid = (cnt_r != '0);
  assign pop        = head_pop && head_valid;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    item.value = in_tdata;
    item.zero  = (in_tdata == '0);
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

FILE: rtl/ddf_back.sv
`include "decimal_digit_display_formatter_top_defines.svh"

module ddf_back
  import ddf_pkg::*;
#(
  parameter int DIGIT_POSITIONS = DIGIT_POSITIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  ddf_item_t             head,
  output logic                  head_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  localparam int POS_W = $clog2(DIGIT_POSITIONS);

  logic                  busy_r, busy_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [VALUE_W-1:0]    rest_r, rest_nxt;
  logic                  zero_r, zero_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  step, last_pos;
  logic [PROD_W-1:0]     prod;
  logic [VALUE_W-1:0]    quot, quot10, rem;
  logic [CODE_W-1:0]     code;
  logic [REG_W-1:0]      digit_reg;

  assign step     = busy_r && (!out_valid_r || out_tready);
  assign last_pos = (pos_r == POS_W'(DIGIT_POSITIONS - 1));
  assign head_pop = head_valid && (!busy_r || (step && last_pos));

  assign prod      = PROD_W'(rest_r) * PROD_W'(RECIP_10);
  assign quot      = prod[RECIP_SHIFT +: VALUE_W];
  assign quot10    = (quot << 3) + (quot << 1);
  assign rem       = rest_r - quot10;
  assign digit_reg = REG_W'(pos_r) + REG_W'(1);

  always_comb begin
    if (zero_r && pos_r == '0) begin
      code = ZERO_CODE;
    end else if (rest_r != '0) begin
      code = rem[CODE_W-1:0];
    end else begin
      code = BLANK_CODE;
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    pos_nxt       = pos_r;
    rest_nxt      = rest_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (step) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {code, digit_reg};
      out_last_nxt  = last_pos;
      pos_nxt       = pos_r + POS_W'(1);
      rest_nxt      = quot;
      if (last_pos) begin
        busy_nxt = 1'b0;
      end
    end
    if (head_pop) begin
      busy_nxt = 1'b1;
      pos_nxt  = '0;
      rest_nxt = head.value;
      zero_nxt = head.zero;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r     <= rest_nxt;
    zero_r     <= zero_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `DDF_ASSERT_IMP(a_last_at_top, clk, rst_n, out_tvalid && out_tlast,
    out_tdata[REG_W-1:0] == REG_W'(DIGIT_POSITIONS))
  `DDF_ASSERT_IMP(a_first_not_blank, clk, rst_n,
    out_tvalid && out_tdata[REG_W-1:0] == REG_W'(1),
    out_tdata[OUT_DATA_W-1:REG_W] <= 4'd9)
  `DDF_ASSERT_IMP(a_code_legal, clk, rst_n, out_tvalid,
    out_tdata[OUT_DATA_W-1:REG_W] <= 4'd9 || out_tdata[OUT_DATA_W-1:REG_W] == BLANK_CODE)
  `DDF_ASSERT_NEXT(a_busy_until_last, clk, rst_n, step && !last_pos, busy_r)

endmodule

FILE: rtl/decimal_digit_display_formatter_top.sv
// A run's first beat goes from the queue entry to rest_r, then to the output register.
// Throughput: DIGIT_POSITIONS beats per input item, one beat a cycle unless out_tready
// stalls, set by the one-digit-a-cycle divide-by-ten unit; runs follow without a gap.
// A two-entry queue decouples input acceptance from digit generation.
// Reset: synchronous, active low; clears queue pointers and control, no clearing pass.
module decimal_digit_display_formatter_top
  import ddf_pkg::*;
#(
  parameter int DIGIT_POSITIONS = DIGIT_POSITIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [VALUE_W-1:0]    in_tdata,   // [15:0] value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [3:0] digit_register, [7:4] digit_code
  output logic                  out_tlast
);

  logic      head_valid;
  logic      head_pop;
  ddf_item_t head;

  ddf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  ddf_back #(
    .DIGIT_POSITIONS (DIGIT_POSITIONS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
